[hw/rtl/arpc_pkg.sv]
// Package with shared types and constants of the ARP resolution cache.
`timescale 1ns / 1ps
`default_nettype none
package arpc_pkg;

  localparam int unsigned Entries = 16;
  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CntW = $clog2(Entries + 1);
  localparam int unsigned QDepth = 2;

  localparam logic [1:0] KindData = 2'd0;
  localparam logic [1:0] KindArp  = 2'd1;
  localparam logic [1:0] KindTick = 2'd2;

  localparam logic [2:0] ActSend  = 3'd0;
  localparam logic [2:0] ActReq   = 3'd1;
  localparam logic [2:0] ActReply = 3'd2;
  localparam logic [2:0] ActDropD = 3'd3;
  localparam logic [2:0] ActDropA = 3'd4;
  localparam logic [2:0] ActFull  = 3'd5;

  localparam logic [1:0] StDead  = 2'd0;
  localparam logic [1:0] StAlive = 2'd1;
  localparam logic [1:0] StWait  = 2'd2;

  localparam logic [2:0] CfgOwnIp  = 3'd0;
  localparam logic [2:0] CfgOwnMac = 3'd1;
  localparam logic [2:0] CfgAlive  = 3'd2;
  localparam logic [2:0] CfgDead   = 3'd3;
  localparam logic [2:0] CfgWait   = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] packet_handle;
    logic [31:0] dest_ipv4;
    logic        arp_is_reply;
    logic [31:0] arp_src_ipv4;
    logic [47:0] arp_src_mac;
    logic [31:0] arp_dst_ipv4;
    logic [47:0] arp_dst_mac;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] out_handle;
    logic [47:0] out_mac;
    logic [31:0] out_ipv4;
  } out_item_t;

  // Classified operation handed from the front part to the back part.
  typedef enum logic [1:0] {
    OpData = 2'd0,
    OpReply = 2'd1,
    OpAnswer = 2'd2,
    OpTick = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] handle;
    logic [31:0] key;
    logic [47:0] mac;
  } cmd_t;

endpackage
`default_nettype wire

[hw/rtl/arp_resolution_cache_core.sv]
// Top level of the ARP resolution cache.
// Items enter on in_valid_i / in_stall_o and each carries one event: a data
// send, a received ARP packet or a time tick. Results leave on out_valid_o /
// out_stall_i; an item gives zero or one result. Front end classifies an
// item in the cycle it is accepted and places a command in a two-entry
// queue. The back end handles each command in a lookup step that
// compares all keys and registers the matching entry, then an execute step
// that updates the entry and loads the result register. The back end
// finishes one command before it looks up the next.
// Ignored ARP packets give no result and are dropped in the front end.
// Configuration writes use cfg_valid_i / cfg_ready_o and are taken in any
// cycle; write only while idle. Reset empties the table, clears time and
// loads default timeouts. When the receiver stalls the result register
// holds, the back end waits in execute and the queue then fills, after
// which in_stall_o rises.
`timescale 1ns / 1ps
`default_nettype none
module arp_resolution_cache_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire arpc_pkg::in_item_t in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output arpc_pkg::out_item_t     out_item_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [47:0]        cfg_data_i
);
  import arpc_pkg::*;

  logic [31:0] own_ip_q, alive_q, dead_q, wait_q;
  logic [47:0] own_mac_q;
  logic        cmd_valid, cmd_pop;
  cmd_t        cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q <= '0;
      own_mac_q <= '0;
      alive_q <= 32'd1200000000;
      dead_q <= 32'd100000000;
      wait_q <= 32'd1000000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgOwnIp:  own_ip_q <= cfg_data_i[31:0];
        CfgOwnMac: own_mac_q <= cfg_data_i;
        CfgAlive:  alive_q <= cfg_data_i[31:0];
        CfgDead:   dead_q <= cfg_data_i[31:0];
        CfgWait:   wait_q <= cfg_data_i[31:0];
        default:   ;
      endcase
    end
  end

  arpc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .own_ipv4_i(own_ip_q), .own_mac_i(own_mac_q),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  arpc_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .alive_to_i(alive_q), .dead_to_i(dead_q), .wait_to_i(wait_q),
    .out_valid_o, .out_stall_i, .out_item_o
  );

`ifndef SYNTHESIS
  a_pop_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid) else $error("pop from empty queue");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");
  a_action_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.action <= ActFull) else $error("bad action");
`endif
endmodule
`default_nettype wire

[hw/rtl/arpc_front.sv]
// Front part: accepts items, classifies them and queues commands.
`timescale 1ns / 1ps
`default_nettype none
module arpc_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire arpc_pkg::in_item_t in_item_i,
  input  wire logic [31:0]       own_ipv4_i,
  input  wire logic [47:0]       own_mac_i,
  output logic                   cmd_valid_o,
  output arpc_pkg::cmd_t         cmd_o,
  input  wire logic              cmd_pop_i
);
  import arpc_pkg::*;

  localparam int unsigned QIdxW = $clog2(QDepth);

  cmd_t                 q_mem [QDepth];
  logic [QIdxW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [QIdxW:0]       cnt_q, cnt_d;
  logic                 keep;
  cmd_t                 cmd;
  logic                 push;

  always_comb begin
    keep = 1'b0;
    cmd.op = OpTick;
    cmd.handle = in_item_i.packet_handle;
    cmd.key = in_item_i.dest_ipv4;
    cmd.mac = in_item_i.arp_src_mac;
    case (in_item_i.kind)
      KindData: begin
        keep = 1'b1;
        cmd.op = OpData;
      end
      KindArp: begin
        cmd.key = in_item_i.arp_src_ipv4;
        if (!in_item_i.arp_is_reply) begin
          keep = (in_item_i.arp_dst_ipv4 == own_ipv4_i);
          cmd.op = OpAnswer;
        end else begin
          keep = (in_item_i.arp_dst_ipv4 == own_ipv4_i) &&
                 (in_item_i.arp_dst_mac == own_mac_i);
          cmd.op = OpReply;
        end
      end
      KindTick: begin
        keep = 1'b1;
        cmd.op = OpTick;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_stall_o = (cnt_q == (QIdxW+1)'(QDepth));
  assign push = in_valid_i && !in_stall_o && keep;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o = q_mem[rd_q];

  always_comb begin
    wr_d = push ? wr_q + 1'b1 : wr_q;
    rd_d = cmd_pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QIdxW+1)'(push) - (QIdxW+1)'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= cmd;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/arpc_back.sv]
// Back part: table lookup, entry update and result register.
`timescale 1ns / 1ps
`default_nettype none
module arpc_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  input  wire arpc_pkg::cmd_t    cmd_i,
  output logic                   cmd_pop_o,
  input  wire logic [31:0]       alive_to_i,
  input  wire logic [31:0]       dead_to_i,
  input  wire logic [31:0]       wait_to_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output arpc_pkg::out_item_t    out_item_o
);
  import arpc_pkg::*;

  typedef enum logic {
    SLook,
    SExec
  } state_e;

  state_e               state_q;
  logic [Entries-1:0]   valid_q;
  logic [31:0]          key_q   [Entries];
  logic [1:0]           st_q    [Entries];
  logic [31:0]          stamp_q [Entries];
  logic [47:0]          mac_q   [Entries];
  logic [15:0]          held_q  [Entries];
  logic [31:0]          now_q;
  logic [CntW-1:0]      fill_q;

  logic                 hit_q;
  logic [IdxW-1:0]      idx_q;
  logic [1:0]           e_st_q;
  logic [31:0]          e_age_q;
  logic [47:0]          e_mac_q;
  logic [15:0]          e_held_q;

  logic                 out_valid_q;
  out_item_t            out_q;
  out_item_t            out_d;

  logic                 hit;
  logic [IdxW-1:0]      hidx;
  logic                 expired;
  logic [31:0]          limit;
  logic                 out_free;
  logic                 full;
  logic                 exec;

  always_comb begin
    hit = 1'b0;
    hidx = '0;
    for (int i = 0; i < Entries; i++) begin
      if (valid_q[i] && key_q[i] == cmd_i.key) begin
        hit = 1'b1;
        hidx = IdxW'(i);
      end
    end
  end

  always_comb begin
    case (e_st_q)
      StAlive: limit = alive_to_i;
      StWait:  limit = wait_to_i;
      default: limit = dead_to_i;
    endcase
    expired = e_age_q > limit;
  end

  assign full = (fill_q == CntW'(Entries));
  assign out_free = !out_valid_q || !out_stall_i;
  assign exec = (state_q == SExec) && out_free;
  assign cmd_pop_o = exec;
  assign out_valid_o = out_valid_q;
  assign out_item_o = out_q;

  // Result of the command in execute; a tick leaves it all zero.
  always_comb begin
    out_d = '0;
    case (cmd_i.op)
      OpTick: ;
      OpAnswer: begin
        out_d.action = ActReply;
        out_d.out_mac = cmd_i.mac;
        out_d.out_ipv4 = cmd_i.key;
      end
      OpReply: begin
        if (hit_q && e_st_q == StWait) begin
          out_d.action = ActSend;
          out_d.out_handle = e_held_q;
          out_d.out_mac = cmd_i.mac;
        end else begin
          out_d.action = ActDropA;
          out_d.out_handle = cmd_i.handle;
        end
      end
      default: begin
        if (!hit_q) begin
          if (full) begin
            out_d.action = ActFull;
            out_d.out_handle = cmd_i.handle;
          end else begin
            out_d.action = ActReq;
            out_d.out_mac = '1;
            out_d.out_ipv4 = cmd_i.key;
          end
        end else if (expired) begin
          if (e_st_q == StWait) begin
            out_d.action = ActDropD;
            out_d.out_handle = cmd_i.handle;
          end else begin
            out_d.action = ActReq;
            out_d.out_mac = '1;
            out_d.out_ipv4 = cmd_i.key;
          end
        end else if (e_st_q == StAlive) begin
          out_d.action = ActSend;
          out_d.out_handle = cmd_i.handle;
          out_d.out_mac = e_mac_q;
        end else if (e_st_q == StWait) begin
          out_d.action = ActDropD;
          out_d.out_handle = e_held_q;
        end else begin
          out_d.action = ActDropD;
          out_d.out_handle = cmd_i.handle;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SLook;
      valid_q <= '0;
      now_q <= '0;
      fill_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (exec) begin
        out_valid_q <= (cmd_i.op != OpTick);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        SLook: begin
          if (cmd_valid_i) begin
            state_q <= SExec;
          end
        end
        SExec: begin
          if (out_free) begin
            state_q <= SLook;
            out_q <= out_d;
            case (cmd_i.op)
              OpTick: begin
                now_q <= now_q + 32'd1;
              end
              OpAnswer: ;
              OpReply: begin
                if (hit_q && e_st_q == StWait) begin
                  st_q[idx_q] <= StAlive;
                  stamp_q[idx_q] <= now_q;
                  mac_q[idx_q] <= cmd_i.mac;
                end
              end
              default: begin
                if (!hit_q) begin
                  if (!full) begin
                    valid_q[fill_q[IdxW-1:0]] <= 1'b1;
                    key_q[fill_q[IdxW-1:0]] <= cmd_i.key;
                    st_q[fill_q[IdxW-1:0]] <= StWait;
                    stamp_q[fill_q[IdxW-1:0]] <= now_q;
                    held_q[fill_q[IdxW-1:0]] <= cmd_i.handle;
                    fill_q <= fill_q + 1'b1;
                  end
                end else if (expired) begin
                  if (e_st_q == StWait) begin
                    st_q[idx_q] <= StDead;
                    stamp_q[idx_q] <= now_q;
                  end else begin
                    st_q[idx_q] <= StWait;
                    stamp_q[idx_q] <= now_q;
                    held_q[idx_q] <= cmd_i.handle;
                  end
                end else if (e_st_q == StWait) begin
                  held_q[idx_q] <= cmd_i.handle;
                end
              end
            endcase
          end
        end
        default: state_q <= SLook;
      endcase
    end
  end

  // Lookup results registered for the execute step.
  always_ff @(posedge clk_i) begin
    hit_q <= hit;
    idx_q <= hidx;
    e_st_q <= st_q[hidx];
    e_age_q <= now_q - stamp_q[hidx];
    e_mac_q <= mac_q[hidx];
    e_held_q <= held_q[hidx];
  end
endmodule
`default_nettype wire

[tb/arpc_checker.sv]
// Checker that predicts the ARP resolution cache results and compares them.
`timescale 1ns / 1ps
module arpc_checker (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_stall_i,
  input  wire arpc_pkg::in_item_t  in_item_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_stall_i,
  input  wire arpc_pkg::out_item_t out_item_i,
  input  wire logic                cfg_valid_i,
  input  wire logic                cfg_ready_i,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [47:0]         cfg_data_i,
  output int                       errors_o,
  output int                       pending_o,
  output int                       results_o
);
  import arpc_pkg::*;

  logic [31:0] own_ip;
  logic [47:0] own_mac;
  logic [31:0] alive_to, dead_to, wait_to;
  logic        ent_valid [Entries];
  logic [31:0] ent_key   [Entries];
  logic [1:0]  ent_state [Entries];
  logic [31:0] ent_stamp [Entries];
  logic [47:0] ent_mac   [Entries];
  logic [15:0] ent_held  [Entries];
  logic [31:0] now;

  out_item_t expected_q[$];

  function automatic out_item_t mk(logic [2:0] a, logic [15:0] h, logic [47:0] m,
                                   logic [31:0] ip);
    out_item_t r;
    r.action = a; r.out_handle = h; r.out_mac = m; r.out_ipv4 = ip;
    return r;
  endfunction

  function automatic int lookup(logic [31:0] key);
    for (int i = 0; i < Entries; i++)
      if (ent_valid[i] && ent_key[i] == key) return i;
    return -1;
  endfunction

  // Advances the predicted table by one item and queues its result, if any.
  task automatic resolve(in_item_t it);
    int i;
    logic [31:0] lim;
    logic [15:0] old;
    if (it.kind == KindTick) begin
      now = now + 32'd1;
    end else if (it.kind == KindData) begin
      i = lookup(it.dest_ipv4);
      if (i < 0) begin
        for (i = 0; i < Entries; i++) if (!ent_valid[i]) break;
        if (i >= Entries) begin
          expected_q.push_back(mk(ActFull, it.packet_handle, '0, '0));
        end else begin
          ent_valid[i] = 1'b1; ent_key[i] = it.dest_ipv4;
          ent_state[i] = StWait; ent_stamp[i] = now; ent_held[i] = it.packet_handle;
          expected_q.push_back(mk(ActReq, '0, '1, it.dest_ipv4));
        end
      end else begin
        lim = (ent_state[i] == StAlive) ? alive_to :
              (ent_state[i] == StWait) ? wait_to : dead_to;
        if (now - ent_stamp[i] > lim) begin
          if (ent_state[i] == StWait) begin
            ent_state[i] = StDead; ent_stamp[i] = now;
            expected_q.push_back(mk(ActDropD, it.packet_handle, '0, '0));
          end else begin
            ent_state[i] = StWait; ent_stamp[i] = now; ent_held[i] = it.packet_handle;
            expected_q.push_back(mk(ActReq, '0, '1, it.dest_ipv4));
          end
        end else if (ent_state[i] == StAlive) begin
          expected_q.push_back(mk(ActSend, it.packet_handle, ent_mac[i], '0));
        end else if (ent_state[i] == StWait) begin
          old = ent_held[i];
          ent_held[i] = it.packet_handle;
          expected_q.push_back(mk(ActDropD, old, '0, '0));
        end else begin
          expected_q.push_back(mk(ActDropD, it.packet_handle, '0, '0));
        end
      end
    end else if (it.kind == KindArp) begin
      if (!it.arp_is_reply) begin
        if (it.arp_dst_ipv4 == own_ip)
          expected_q.push_back(mk(ActReply, '0, it.arp_src_mac, it.arp_src_ipv4));
      end else if (it.arp_dst_ipv4 == own_ip && it.arp_dst_mac == own_mac) begin
        i = lookup(it.arp_src_ipv4);
        if (i >= 0 && ent_state[i] == StWait) begin
          ent_state[i] = StAlive; ent_stamp[i] = now; ent_mac[i] = it.arp_src_mac;
          expected_q.push_back(mk(ActSend, ent_held[i], it.arp_src_mac, '0));
        end else begin
          expected_q.push_back(mk(ActDropA, it.packet_handle, '0, '0));
        end
      end
    end
  endtask

  task automatic compare(out_item_t got);
    out_item_t exp;
    if (expected_q.size() == 0) begin
      $error("result with nothing expected: action %0d handle %h", got.action,
             got.out_handle);
      errors_o++;
    end else begin
      exp = expected_q.pop_front();
      if (got.action !== exp.action) begin
        $error("action: expected %0d, got %0d", exp.action, got.action);
        errors_o++;
      end
      if (got.out_handle !== exp.out_handle) begin
        $error("out_handle: expected %h, got %h", exp.out_handle, got.out_handle);
        errors_o++;
      end
      if (got.out_mac !== exp.out_mac) begin
        $error("out_mac: expected %h, got %h", exp.out_mac, got.out_mac);
        errors_o++;
      end
      if (got.out_ipv4 !== exp.out_ipv4) begin
        $error("out_ipv4: expected %h, got %h", exp.out_ipv4, got.out_ipv4);
        errors_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip <= '0; own_mac <= '0;
      alive_to <= 32'd1200000000; dead_to <= 32'd100000000; wait_to <= 32'd1000000;
      now <= '0;
      for (int i = 0; i < Entries; i++) ent_valid[i] <= 1'b0;
      expected_q.delete();
      errors_o <= 0;
      results_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgOwnIp:  own_ip <= cfg_data_i[31:0];
          CfgOwnMac: own_mac <= cfg_data_i;
          CfgAlive:  alive_to <= cfg_data_i[31:0];
          CfgDead:   dead_to <= cfg_data_i[31:0];
          CfgWait:   wait_to <= cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        compare(out_item_i);
        results_o <= results_o + 1;
      end
      if (in_valid_i && !in_stall_i) resolve(in_item_i);
    end
  end

  assign pending_o = expected_q.size();
endmodule

[tb/tb_top.sv]
// Top of the ARP resolution cache testbench: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_top;
  import arpc_pkg::*;

  logic        clk, rst_n;
  logic        in_valid, in_stall, out_valid, out_stall;
  in_item_t    in_item;
  out_item_t   out_item;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;
  int          errors, pending, results;
  int          cycles;
  bit          calm, hold_rx;

  logic [31:0] my_ip;
  logic [47:0] my_mac;
  logic [31:0] peers [8];
  int          ntick;
  int          nitems;

  arp_resolution_cache_core uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  arpc_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_item_i(in_item),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_item_i(out_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Receiver stalls: random, off in the calm phase, or held by the long hold-off.
  always @(posedge clk) begin
    if (hold_rx) out_stall <= 1'b1;
    else if (calm) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 18);
  end

  task automatic cfg_write(logic [2:0] idx, logic [47:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Waits until the block has produced everything and is quiet.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Offers one item; consecutive calls can present items back to back.
  task automatic send(in_item_t it);
    if (!calm) while ($urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; in_item <= it;
    do @(posedge clk); while (in_stall);
    nitems++;
  endtask

  function automatic in_item_t noise();
    in_item_t it;
    it = $bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom});
    it.kind = 2'($urandom_range(3));
    return it;
  endfunction

  function automatic in_item_t data_to(logic [31:0] ip);
    in_item_t it;
    it = noise();
    it.kind = KindData; it.dest_ipv4 = ip;
    return it;
  endfunction

  function automatic in_item_t arp(bit rep, logic [31:0] src, logic [31:0] dst,
                                   logic [47:0] dmac);
    in_item_t it;
    it = noise();
    it.kind = KindArp; it.arp_is_reply = rep;
    it.arp_src_ipv4 = src; it.arp_dst_ipv4 = dst; it.arp_dst_mac = dmac;
    return it;
  endfunction

  function automatic in_item_t tick();
    in_item_t it;
    it = noise();
    it.kind = KindTick;
    return it;
  endfunction

  task automatic set_timeouts(logic [31:0] a, logic [31:0] d, logic [31:0] w);
    cfg_write(CfgAlive, {16'd0, a});
    cfg_write(CfgDead, {16'd0, d});
    cfg_write(CfgWait, {16'd0, w});
  endtask

  task automatic random_phase(int n);
    int r;
    in_item_t it;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 35) it = data_to(peers[$urandom_range(7)]);
      else if (r < 45) it = data_to($urandom);
      else if (r < 60) it = arp(1'b1, peers[$urandom_range(7)], my_ip, my_mac);
      else if (r < 68) it = arp(1'b0, $urandom, my_ip, 48'($urandom));
      else if (r < 88) it = tick();
      else it = noise();
      send(it);
    end
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_item = '0; out_stall = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    cycles = 0; calm = 1'b0; hold_rx = 1'b0; nitems = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under reset timeouts and an all-zero own address.
    send(arp(1'b0, 32'h0a000001, 32'h0, 48'h1));
    send(data_to(32'hffffffff));
    send(data_to(32'h0));
    send(data_to(32'h0));
    send(arp(1'b1, 32'h0, 32'h0, 48'h0));
    send(data_to(32'h0));
    send(arp(1'b1, 32'h0, 32'h0, 48'h0));
    send(arp(1'b1, 32'h5, 32'h0, 48'h0));
    send(arp(1'b1, 32'h0, 32'h1, 48'h0));
    send(arp(1'b0, 32'h5, 32'h1, 48'h0));
    send(tick());
    drain();

    my_ip = 32'hffffffff; my_mac = 48'hffffffffffff;
    cfg_write(CfgOwnIp, {16'd0, my_ip});
    cfg_write(CfgOwnMac, my_mac);
    set_timeouts(32'd0, 32'd0, 32'd0);
    send(data_to(32'h7));
    send(tick());
    send(data_to(32'h7));
    send(data_to(32'h7));
    send(tick());
    send(data_to(32'h7));
    send(arp(1'b1, 32'h7, my_ip, my_mac));
    send(data_to(32'h7));
    send(tick());
    send(data_to(32'h7));
    for (int k = 0; k < 16; k++) send(data_to(32'h100 + k));
    drain();

    // Random phases at several timeout settings; reset comes only at the start,
    // so the table stays full and later phases mostly reuse known peers.
    my_ip = $urandom; my_mac = 48'({$urandom, $urandom});
    cfg_write(CfgOwnIp, {16'd0, my_ip});
    cfg_write(CfgOwnMac, my_mac);
    for (int p = 0; p < 8; p++) peers[p] = (p < 6) ? 32'h100 + p : 32'h7;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_timeouts(32'd3, 32'd2, 32'd1);
        1: set_timeouts(32'hffffffff, 32'hffffffff, 32'hffffffff);
        2: set_timeouts(32'd10, 32'd5, 32'd4);
        default: set_timeouts($urandom_range(20), $urandom_range(8), $urandom_range(6));
      endcase
      calm = (ph == 1);
      random_phase(380);
      if (ph == 2) begin
        // Long receiver hold-off while items keep coming, in its own process.
        fork
          begin
            hold_rx = 1'b1;
            repeat (60) @(posedge clk);
            hold_rx = 1'b0;
          end
          random_phase(20);
        join
      end
      drain();
    end
    // The sender pauses here until every result is in, then a final burst.
    random_phase(60);
    drain();

    $display("tb_top: %0d items sent, %0d results checked over several timeout settings",
             nitems, results);
    $display("tb_top: covered sends, requests, replies, expiry and a full table");
    if (errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end
endmodule

[arp_resolution_cache_core.f]
hw/rtl/arpc_pkg.sv
hw/rtl/arpc_front.sv
hw/rtl/arpc_back.sv
hw/rtl/arp_resolution_cache_core.sv
tb/arpc_checker.sv
tb/tb_top.sv
